[hdl/base64_stream_decoder_core_macros.svh]
// assertion macros shared by the base64 stream decoder checker
// no dependencies; included by files that carry concurrent assertions
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define B64SD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/b64sd_pkg.sv]
// types, constants and the character lookup of the base64 stream decoder
// no dependencies; imported by every decoder module
`timescale 1ns / 1ps

package b64sd_pkg;

    // pad character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // sextet values of the two alphabet-dependent characters
    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    // index of the last byte a command carries
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;

    // one decoded group handed from the front end to the back end
    typedef struct packed {
        logic [23:0] bytes;     // first byte in the top bits
        logic [1:0]  last_idx;  // index of the last byte to send
        logic        is_end;    // group closes the string
        logic        is_err;    // string rejected, single error result
    } b64sd_cmd_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic not_empty;
    } b64sd_qstat_t;

    // character to {valid, sextet}; sextet is zero when invalid
    function automatic logic [6:0] b64sd_sextet(input logic [7:0] c, input logic mode);
        logic [6:0] res;
        res = 7'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            res = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            res = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            res = {1'b1, SEXTET_62};
        end else if (c == 8'h2F) begin
            res = {1'b1, SEXTET_63};
        end else if (mode && (c == 8'h2D)) begin
            res = {1'b1, SEXTET_62};
        end else if (mode && (c == 8'h5F)) begin
            res = {1'b1, SEXTET_63};
        end
        return res;
    endfunction

endpackage

[hdl/b64sd_front.sv]
// front end: accepts characters, gathers groups of four, decodes finished groups
// depends on b64sd_pkg; feeds b64sd_queue
`timescale 1ns / 1ps

module b64sd_front
    import b64sd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         alphabet_mode,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] character
    input  logic         s_tlast,
    input  b64sd_qstat_t q_stat,
    output logic         push,
    output b64sd_cmd_t   push_cmd
);

    logic [7:0] group_chars_reg [3];
    logic [1:0] chars_held_reg;
    logic [1:0] chars_held_next;
    logic       error_seen_reg;
    logic       error_seen_next;

    logic       accept;
    logic [6:0] sx0, sx1, sx2, sxc;
    logic       grp_ok;
    logic       fin_ok;
    logic       fin_bad;

    // space in the queue for one more group
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // lookups with the mode in force when the group completes
    assign sx0 = b64sd_sextet(group_chars_reg[0], alphabet_mode);
    assign sx1 = b64sd_sextet(group_chars_reg[1], alphabet_mode);
    assign sx2 = b64sd_sextet(group_chars_reg[2], alphabet_mode);
    assign sxc = b64sd_sextet(s_tdata, alphabet_mode);

    // group completion and command build
    always_comb begin
        chars_held_next = chars_held_reg;
        error_seen_next = error_seen_reg;
        push            = 1'b0;
        push_cmd        = '0;
        grp_ok          = sx0[6] && sx1[6] && sx2[6] && sxc[6];
        fin_ok          = 1'b0;
        fin_bad         = 1'b0;
        if (accept) begin
            if (!s_tlast) begin
                if (chars_held_reg != 2'd3) begin
                    chars_held_next = chars_held_reg + 2'd1;
                end else begin
                    chars_held_next   = 2'd0;
                    error_seen_next   = error_seen_reg || !grp_ok;
                    push              = !error_seen_next;
                    push_cmd.bytes    = {sx0[5:0], sx1[5:0], sx2[5:0], sxc[5:0]};
                    push_cmd.last_idx = LAST_IDX_THREE;
                end
            end else begin
                chars_held_next = 2'd0;
                error_seen_next = 1'b0;
                push            = 1'b1;
                push_cmd.is_end = 1'b1;
                case (chars_held_reg)
                    2'd0: begin
                        // lone leftover character
                        fin_ok = 1'b0;
                    end
                    2'd1: begin
                        fin_ok            = sx0[6] && sxc[6];
                        push_cmd.bytes    = {sx0[5:0], sxc[5:0], 12'd0};
                        push_cmd.last_idx = LAST_IDX_ONE;
                    end
                    2'd2: begin
                        fin_ok            = sx0[6] && sx1[6] && sxc[6];
                        push_cmd.bytes    = {sx0[5:0], sx1[5:0], sxc[5:0], 6'd0};
                        push_cmd.last_idx = LAST_IDX_TWO;
                    end
                    2'd3: begin
                        if (s_tdata == PAD_CHAR) begin
                            if (group_chars_reg[2] == PAD_CHAR) begin
                                // two pad characters stripped
                                fin_ok            = sx0[6] && sx1[6];
                                push_cmd.bytes    = {sx0[5:0], sx1[5:0], 12'd0};
                                push_cmd.last_idx = LAST_IDX_ONE;
                            end else begin
                                fin_ok            = sx0[6] && sx1[6] && sx2[6];
                                push_cmd.bytes    = {sx0[5:0], sx1[5:0], sx2[5:0], 6'd0};
                                push_cmd.last_idx = LAST_IDX_TWO;
                            end
                        end else begin
                            fin_ok            = grp_ok;
                            push_cmd.bytes    = {sx0[5:0], sx1[5:0], sx2[5:0], sxc[5:0]};
                            push_cmd.last_idx = LAST_IDX_THREE;
                        end
                    end
                    default: begin
                        fin_ok = 1'b0;
                    end
                endcase
                fin_bad = error_seen_reg || !fin_ok;
                if (fin_bad) begin
                    push_cmd.bytes    = 24'd0;
                    push_cmd.last_idx = LAST_IDX_ONE;
                    push_cmd.is_err   = 1'b1;
                end
            end
        end
    end

    // held characters of the current group
    always_ff @(posedge aclk) begin
        if (accept && !s_tlast && (chars_held_reg != 2'd3)) begin
            group_chars_reg[chars_held_reg] <= s_tdata;
        end
    end

    // group count and sticky error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_held_reg <= 2'd0;
            error_seen_reg <= 1'b0;
        end else begin
            chars_held_reg <= chars_held_next;
            error_seen_reg <= error_seen_next;
        end
    end

endmodule

[hdl/b64sd_queue.sv]
// command queue between the front end and the back end
// depends on b64sd_pkg
`timescale 1ns / 1ps

module b64sd_queue
    import b64sd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  b64sd_cmd_t   push_cmd,
    input  logic         pop,
    output b64sd_cmd_t   pop_cmd,
    output b64sd_qstat_t q_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b64sd_cmd_t      entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    // status and head entry
    assign q_stat.full      = (count_reg == CW'(DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign pop_cmd          = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

endmodule

[hdl/b64sd_back.sv]
// back end: takes decoded groups from the queue and sends their bytes one by one
// depends on b64sd_pkg; fed by b64sd_queue
`timescale 1ns / 1ps

module b64sd_back
    import b64sd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  b64sd_qstat_t q_stat,
    input  b64sd_cmd_t   pop_cmd,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,     // [7:0] data_byte
    output logic         m_tlast,
    output logic         m_tuser      // [0] decode_error
);

    b64sd_cmd_t cmd_reg;
    logic       cmd_valid_reg;
    logic [1:0] idx_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic       out_free;
    logic       emit;
    logic       at_last;
    logic       cmd_done;
    logic       load;
    logic [7:0] byte_sel;

    // one byte per transaction while the output slot is free
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = cmd_valid_reg && out_free;
    assign at_last  = (idx_reg == cmd_reg.last_idx);
    assign cmd_done = emit && at_last;
    assign load     = q_stat.not_empty && (!cmd_valid_reg || cmd_done);
    assign pop      = load;

    // byte of the current group
    always_comb begin
        case (idx_reg)
            LAST_IDX_ONE:   byte_sel = cmd_reg.bytes[23:16];
            LAST_IDX_TWO:   byte_sel = cmd_reg.bytes[15:8];
            LAST_IDX_THREE: byte_sel = cmd_reg.bytes[7:0];
            default:        byte_sel = 8'd0;
        endcase
    end

    // current command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            cmd_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end else if (cmd_done) begin
            cmd_valid_reg <= 1'b0;
        end else if (emit) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= pop_cmd;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= cmd_reg.is_end && at_last;
            m_tuser_reg <= cmd_reg.is_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/base64_stream_decoder_core.sv]
// top level of the base64 stream decoder: front end, command queue, back end
// depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back
`timescale 1ns / 1ps

// Decodes a base64 string arriving as one character per transaction, with
// s_tlast on the last character. The block takes one character every cycle for
// as long as its command queue (QUEUE_DEPTH decoded groups) has room; s_tready
// drops only when that queue is full. Each completed group is decoded in the
// cycle its last character is taken and leaves as one to three bytes, one byte
// per cycle unless m_tready stalls it, via the command queue, a command
// register and an output register. An invalid character or a lone leftover
// character makes the string end in a single result with byte 0, m_tlast and
// m_tuser set. cfg_wr_data selects the alphabet: 0 standard, 1 also accepts
// '-' and '_'; write it between strings or mid-group only.

module base64_stream_decoder_core
    import b64sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // [0] alphabet_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] character
    input  logic       s_tlast,       // final_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] data_byte
    output logic       m_tlast,       // end_of_data
    output logic       m_tuser        // [0] decode_error
);

    logic         alphabet_mode_reg;
    logic         push;
    b64sd_cmd_t   push_cmd;
    logic         pop;
    b64sd_cmd_t   pop_cmd;
    b64sd_qstat_t q_stat;

    // alphabet register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alphabet_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            alphabet_mode_reg <= cfg_wr_data;
        end
    end

    b64sd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .alphabet_mode (alphabet_mode_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    b64sd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hdl/b64sd_checker.sv]
// port-level checks of the base64 stream decoder, attached by bind
// depends on base64_stream_decoder_core_macros.svh and base64_stream_decoder_core
`timescale 1ns / 1ps
`include "base64_stream_decoder_core_macros.svh"

module b64sd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a stalled result keeps its contents
    `B64SD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // an error result closes the string and carries no byte
    `B64SD_ASSERT_NOW(a_err_form, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0), "malformed error result")

    // reset empties the output register
    `B64SD_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // reset empties the queue, so the input is ready right after it
    `B64SD_ASSERT_ALWAYS_NEXT(a_reset_ready, aclk, !aresetn, s_tready, "input not ready after reset")

endmodule

bind base64_stream_decoder_core b64sd_checker u_b64sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
